[sv/rotation_matrix_to_quaternion_top_defines.svh]
// assertion macros shared by the rotation matrix to quaternion block
// expects signals named clock and reset in the module that uses them
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH

// expression must hold at every clock edge out of reset
`define RMQ_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/rmq_pkg.sv]
// types, widths and codes for the rotation matrix to quaternion block
// no dependencies
package rmq_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 14;
   localparam int ONE        = 1 << FRAC_BITS;

   // signed width that holds any three-element sum plus one
   localparam int SUM_W      = DATA_WIDTH + 3;
   // clamped radicand, unsigned
   localparam int RAD_W      = DATA_WIDTH + 1;
   // square root: one result bit per stage
   localparam int SQ_STEPS   = (RAD_W + FRAC_BITS + 1) / 2;
   localparam int ROOT_W     = SQ_STEPS;
   localparam int SQ_IN_W    = 2 * SQ_STEPS;
   localparam int SQ_REM_W   = ROOT_W + 2;
   // pair sum or difference magnitude
   localparam int MAG_W      = DATA_WIDTH + 1;
   // divider: one quotient bit per stage
   localparam int DIV_STEPS  = MAG_W + FRAC_BITS;
   localparam int DVS_W      = ROOT_W + 1;
   localparam int DIV_REM_W  = ROOT_W + 2;

   typedef logic signed [DATA_WIDTH-1:0] elem_type;

   typedef enum logic [1:0] {
      PIV_W,
      PIV_X,
      PIV_Y,
      PIV_Z
   } pivot_type;

   typedef struct packed {
      elem_type m00, m01, m02;
      elem_type m10, m11, m12;
      elem_type m20, m21, m22;
   } mat_type;

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } term_type;

   // term index: 0 w, 1 x, 2 y, 3 z
   typedef struct packed {
      pivot_type      pivot;
      term_type [3:0] term;
   } pass_type;

   typedef struct packed {
      logic [RAD_W-1:0] rad;
      pass_type         pass;
   } prep_type;

   typedef struct packed {
      logic [ROOT_W-1:0] root;
      pass_type          pass;
   } root_type;

   typedef struct packed {
      elem_type  qw, qx, qy, qz;
      pivot_type pivot;
   } quat_type;

endpackage

[sv/rmq_req_if.sv]
// request channel: one rotation matrix per transfer
// depends on rmq_pkg
interface rmq_req_if;
   import rmq_pkg::*;

   logic     valid;
   logic     ready;
   elem_type m00, m01, m02;
   elem_type m10, m11, m12;
   elem_type m20, m21, m22;

   modport source (
      output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
      input  ready
   );
   modport sink (
      input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
      output ready
   );
endinterface

[sv/rmq_rsp_if.sv]
// response channel: one quaternion and its pivot per transfer
// depends on rmq_pkg
interface rmq_rsp_if;
   import rmq_pkg::*;

   logic      valid;
   logic      ready;
   elem_type  qw, qx, qy, qz;
   logic [1:0] pivot;

   modport source (
      output valid, qw, qx, qy, qz, pivot,
      input  ready
   );
   modport sink (
      input  valid, qw, qx, qy, qz, pivot,
      output ready
   );
endinterface

[sv/rmq_front.sv]
// front end: trace, diagonal compares, pivot choice, radicand and pair terms
// two register stages; depends on rmq_pkg and the defines header
`include "rotation_matrix_to_quaternion_top_defines.svh"

module rmq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rmq_pkg::mat_type  in_mat,
   output logic              out_valid,
   input  logic              out_ready,
   output rmq_pkg::prep_type out_prep
);
   import rmq_pkg::*;

   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic signed [MAG_W-1:0] pair_type;

   function automatic term_type to_term(input pair_type v);
      term_type t;
      t.neg = v[MAG_W-1];
      t.mag = t.neg ? MAG_W'(-v) : MAG_W'(v);
      return t;
   endfunction

   // stage a
   logic     a_valid_ff;
   logic     a_ready;
   sum_type  a_trace_ff, a_trace_in;
   logic     a_c10_ff, a_c20_ff, a_c21_ff;
   sum_type  a_rad_ff [4];
   sum_type  a_rad_in [4];
   pair_type a_dif_ff [3];
   pair_type a_dif_in [3];
   pair_type a_sum_ff [3];
   pair_type a_sum_in [3];

   // stage b
   logic      b_valid_ff;
   logic      b_ready;
   prep_type  b_prep_ff, b_prep_in;
   pivot_type piv;
   sum_type   rad_sel;

   sum_type m00, m11, m22, one_s;

   assign m00   = SUM_W'(in_mat.m00);
   assign m11   = SUM_W'(in_mat.m11);
   assign m22   = SUM_W'(in_mat.m22);
   assign one_s = SUM_W'(ONE);

   assign a_trace_in  = m00 + m11 + m22;
   assign a_rad_in[0] = a_trace_in + one_s;
   assign a_rad_in[1] = m00 - m11 - m22 + one_s;
   assign a_rad_in[2] = m11 - m22 - m00 + one_s;
   assign a_rad_in[3] = m22 - m00 - m11 + one_s;

   // differences: x-axis, y-axis, z-axis pairs
   assign a_dif_in[0] = pair_type'(in_mat.m21) - pair_type'(in_mat.m12);
   assign a_dif_in[1] = pair_type'(in_mat.m02) - pair_type'(in_mat.m20);
   assign a_dif_in[2] = pair_type'(in_mat.m10) - pair_type'(in_mat.m01);
   // sums: xy, xz, yz pairs
   assign a_sum_in[0] = pair_type'(in_mat.m10) + pair_type'(in_mat.m01);
   assign a_sum_in[1] = pair_type'(in_mat.m20) + pair_type'(in_mat.m02);
   assign a_sum_in[2] = pair_type'(in_mat.m21) + pair_type'(in_mat.m12);

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
      if (a_ready && in_valid) begin
         a_trace_ff <= a_trace_in;
         a_c10_ff   <= in_mat.m11 > in_mat.m00;
         a_c20_ff   <= in_mat.m22 > in_mat.m00;
         a_c21_ff   <= in_mat.m22 > in_mat.m11;
         a_rad_ff   <= a_rad_in;
         a_dif_ff   <= a_dif_in;
         a_sum_ff   <= a_sum_in;
      end
   end

   // ties keep the lower axis
   always_comb begin
      if (a_trace_ff > 0) begin
         piv = PIV_W;
      end else if (a_c10_ff) begin
         piv = a_c21_ff ? PIV_Z : PIV_Y;
      end else begin
         piv = a_c20_ff ? PIV_Z : PIV_X;
      end
   end

   always_comb begin
      b_prep_in.pass.pivot = piv;
      b_prep_in.pass.term  = '0;
      rad_sel              = a_rad_ff[0];
      case (piv)
         PIV_W: begin
            rad_sel                 = a_rad_ff[0];
            b_prep_in.pass.term[1] = to_term(a_dif_ff[0]);
            b_prep_in.pass.term[2] = to_term(a_dif_ff[1]);
            b_prep_in.pass.term[3] = to_term(a_dif_ff[2]);
         end
         PIV_X: begin
            rad_sel                 = a_rad_ff[1];
            b_prep_in.pass.term[0] = to_term(a_dif_ff[0]);
            b_prep_in.pass.term[2] = to_term(a_sum_ff[0]);
            b_prep_in.pass.term[3] = to_term(a_sum_ff[1]);
         end
         PIV_Y: begin
            rad_sel                 = a_rad_ff[2];
            b_prep_in.pass.term[0] = to_term(a_dif_ff[1]);
            b_prep_in.pass.term[1] = to_term(a_sum_ff[0]);
            b_prep_in.pass.term[3] = to_term(a_sum_ff[2]);
         end
         PIV_Z: begin
            rad_sel                 = a_rad_ff[3];
            b_prep_in.pass.term[0] = to_term(a_dif_ff[2]);
            b_prep_in.pass.term[1] = to_term(a_sum_ff[1]);
            b_prep_in.pass.term[2] = to_term(a_sum_ff[2]);
         end
         default: begin
            rad_sel = a_rad_ff[0];
         end
      endcase
      // negative radicand clamps to zero
      b_prep_in.rad = rad_sel[SUM_W-1] ? '0 : rad_sel[RAD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready && a_valid_ff) begin
         b_prep_ff <= b_prep_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_prep  = b_prep_ff;

   `RMQ_ASSERT_NEXT(a_pivot_w_trace, a_valid_ff && b_ready,
      (b_prep_ff.pass.pivot == PIV_W) == $past(a_trace_ff > 0), "pivot w disagrees with trace")

endmodule

[sv/rmq_sqrt.sv]
// pipelined integer square root, one root bit per stage
// carries the pivot and pair terms alongside; depends on rmq_pkg
module rmq_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rmq_pkg::prep_type in_prep,
   output logic              out_valid,
   input  logic              out_ready,
   output rmq_pkg::root_type out_root
);
   import rmq_pkg::*;

   logic                v_ff    [SQ_STEPS];
   logic                rdy     [SQ_STEPS];
   logic [SQ_IN_W-1:0]  rad_ff  [SQ_STEPS];
   logic [SQ_REM_W-1:0] rem_ff  [SQ_STEPS];
   logic [ROOT_W-1:0]   root_ff [SQ_STEPS];
   pass_type            pass_ff [SQ_STEPS];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
      logic                v_src;
      logic                rdy_next;
      logic [SQ_IN_W-1:0]  rad_src, rad_in;
      logic [SQ_REM_W-1:0] rem_src, rem_in, rem_sh;
      logic [ROOT_W-1:0]   root_src, root_in;
      pass_type            pass_src;
      logic [SQ_REM_W:0]   trial;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign rad_src  = SQ_IN_W'({in_prep.rad, {FRAC_BITS{1'b0}}});
         assign rem_src  = '0;
         assign root_src = '0;
         assign pass_src = in_prep.pass;
      end else begin : g_next
         assign v_src    = v_ff[k-1];
         assign rad_src  = rad_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign pass_src = pass_ff[k-1];
      end

      if (k == SQ_STEPS - 1) begin : g_last
         assign rdy_next = out_ready;
      end else begin : g_mid
         assign rdy_next = rdy[k+1];
      end

      assign rdy[k] = !v_ff[k] || rdy_next;

      // bring down two radicand bits, try subtracting 4*root+1
      assign rem_sh  = {rem_src[SQ_REM_W-3:0], rad_src[SQ_IN_W-1 -: 2]};
      assign trial   = {1'b0, rem_sh} - {1'b0, root_src, 2'b01};
      assign rad_in  = {rad_src[SQ_IN_W-3:0], 2'b00};
      assign rem_in  = trial[SQ_REM_W] ? rem_sh : trial[SQ_REM_W-1:0];
      assign root_in = {root_src[ROOT_W-2:0], !trial[SQ_REM_W]};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= v_src;
         end
         if (rdy[k] && v_src) begin
            rad_ff[k]  <= rad_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            pass_ff[k] <= pass_src;
         end
      end
   end

   assign in_ready      = rdy[0];
   assign out_valid     = v_ff[SQ_STEPS-1];
   assign out_root.root = root_ff[SQ_STEPS-1];
   assign out_root.pass = pass_ff[SQ_STEPS-1];

endmodule

[sv/rmq_div.sv]
// four-lane pipelined divider, one quotient bit per stage, then saturation
// and the output register; depends on rmq_pkg and the defines header
`include "rotation_matrix_to_quaternion_top_defines.svh"

module rmq_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rmq_pkg::root_type in_root,
   output logic              out_valid,
   input  logic              out_ready,
   output rmq_pkg::quat_type out_quat
);
   import rmq_pkg::*;

   typedef struct packed {
      logic [ROOT_W-1:0] root;
      pivot_type         pivot;
      logic [3:0]        neg;
   } ctl_type;

   localparam int MAX_POS = (1 << (DATA_WIDTH - 1)) - 1;

   function automatic elem_type sat(input logic neg, input logic [DIV_STEPS-1:0] mag);
      elem_type r;
      if (!neg) begin
         r = (mag > DIV_STEPS'(MAX_POS)) ? elem_type'(MAX_POS) : elem_type'(mag[DATA_WIDTH-1:0]);
      end else begin
         r = (mag > DIV_STEPS'(MAX_POS)) ? elem_type'(-MAX_POS - 1)
                                        : -elem_type'(mag[DATA_WIDTH-1:0]);
      end
      return r;
   endfunction

   logic                 v_ff   [DIV_STEPS];
   logic                 rdy    [DIV_STEPS];
   ctl_type              ctl_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] num_ff [DIV_STEPS][4];
   logic [DIV_REM_W-1:0] rem_ff [DIV_STEPS][4];

   logic                 out_valid_ff;
   logic                 out_rdy;
   quat_type             quat_ff, quat_in;
   elem_type             q [4];
   ctl_type              ctl_last;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
      logic          v_src;
      logic          rdy_next;
      ctl_type       ctl_src;
      logic [DVS_W-1:0] dvs;

      if (k == 0) begin : g_first
         assign v_src = in_valid;
         assign ctl_src.root  = in_root.root;
         assign ctl_src.pivot = in_root.pass.pivot;
         assign ctl_src.neg   = {in_root.pass.term[3].neg, in_root.pass.term[2].neg,
                                 in_root.pass.term[1].neg, in_root.pass.term[0].neg};
      end else begin : g_next
         assign v_src   = v_ff[k-1];
         assign ctl_src = ctl_ff[k-1];
      end

      if (k == DIV_STEPS - 1) begin : g_last
         assign rdy_next = out_rdy;
      end else begin : g_mid
         assign rdy_next = rdy[k+1];
      end

      assign rdy[k] = !v_ff[k] || rdy_next;
      // divisor is twice the root
      assign dvs    = {ctl_src.root, 1'b0};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= v_src;
         end
         if (rdy[k] && v_src) begin
            ctl_ff[k] <= ctl_src;
         end
      end

      for (genvar l = 0; l < 4; l++) begin : g_lane
         logic [DIV_STEPS-1:0] num_src, num_in;
         logic [DIV_REM_W-1:0] rem_src, rem_in, rem_sh;
         logic [DIV_REM_W:0]   trial;

         if (k == 0) begin : g_first
            assign num_src = {in_root.pass.term[l].mag, {FRAC_BITS{1'b0}}};
            assign rem_src = '0;
         end else begin : g_next
            assign num_src = num_ff[k-1][l];
            assign rem_src = rem_ff[k-1][l];
         end

         // quotient bits shift into the low end as dividend bits leave the top
         assign rem_sh = {rem_src[DIV_REM_W-2:0], num_src[DIV_STEPS-1]};
         assign trial  = {1'b0, rem_sh} - (DIV_REM_W+1)'(dvs);
         assign rem_in = trial[DIV_REM_W] ? rem_sh : trial[DIV_REM_W-1:0];
         assign num_in = {num_src[DIV_STEPS-2:0], !trial[DIV_REM_W]};

         always_ff @(posedge clock) begin
            if (rdy[k] && v_src) begin
               num_ff[k][l] <= num_in;
               rem_ff[k][l] <= rem_in;
            end
         end
      end
   end

   assign ctl_last = ctl_ff[DIV_STEPS-1];

   for (genvar l = 0; l < 4; l++) begin : g_sat
      always_comb begin
         if (ctl_last.root == '0) begin
            q[l] = '0;
         end else if (ctl_last.pivot == pivot_type'(l)) begin
            q[l] = sat(1'b0, DIV_STEPS'(ctl_last.root >> 1));
         end else begin
            q[l] = sat(ctl_last.neg[l], num_ff[DIV_STEPS-1][l]);
         end
      end
   end

   assign quat_in.qw    = q[0];
   assign quat_in.qx    = q[1];
   assign quat_in.qy    = q[2];
   assign quat_in.qz    = q[3];
   assign quat_in.pivot = ctl_last.pivot;

   assign out_rdy = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         out_valid_ff <= v_ff[DIV_STEPS-1];
      end
      if (out_rdy && v_ff[DIV_STEPS-1]) begin
         quat_ff <= quat_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = out_valid_ff;
   assign out_quat  = quat_ff;

   `RMQ_ASSERT(a_pivot_nonneg, !(out_valid_ff &&
      ((quat_ff.pivot == PIV_W && quat_ff.qw[DATA_WIDTH-1]) ||
       (quat_ff.pivot == PIV_X && quat_ff.qx[DATA_WIDTH-1]) ||
       (quat_ff.pivot == PIV_Y && quat_ff.qy[DATA_WIDTH-1]) ||
       (quat_ff.pivot == PIV_Z && quat_ff.qz[DATA_WIDTH-1]))), "pivot component negative")
   `RMQ_ASSERT_NEXT(a_last_to_out, v_ff[DIV_STEPS-1] && out_rdy, out_valid_ff, "finished item lost before output register")
   `RMQ_ASSERT_NEXT(a_out_hold, out_valid_ff && !out_ready, out_valid_ff && $stable(quat_ff), "output changed while held")

endmodule

[sv/rotation_matrix_to_quaternion_top.sv]
// Rotation matrix to unit quaternion, signed Q1.14 in and out.
// req_bus carries one 3x3 matrix per transfer (m00..m22); rsp_bus returns
// qw, qx, qy, qz and the pivot code (0 w, 1 x, 2 y, 3 z) for each matrix.
// Path from a request transfer to rsp valid: two front stages,
// 16 square-root stages, 31 divider stages and the output register.
// Throughput: one matrix per cycle while rsp_ready is high; each stage of
// the square root and four divider lanes resolves one bit; bits set depth.
// Every stage has its own valid bit, and a stage loads whenever it is empty
// or the one after it moves, so gaps in the pipe close up while rsp_ready
// is low and req_ready stays high until every stage holds an item.
// A held result stays stable on rsp_bus until transferred; nothing is lost
// or repeated across stalls.
// Reset is synchronous, active high, and empties the pipe; data registers
// are not cleared.
// Negative radicands clamp to zero; a zero root gives an all-zero quaternion;
// every component saturates to the 16-bit signed range.
// Depends on rmq_pkg, the channel interfaces and the rmq_* stage modules.
module rotation_matrix_to_quaternion_top (
   input  logic      clock,
   input  logic      reset,
   rmq_req_if.sink   req_bus,
   rmq_rsp_if.source rsp_bus
);
   import rmq_pkg::*;

   mat_type  mat;
   prep_type prep;
   root_type root;
   quat_type quat;
   logic     prep_valid, prep_ready;
   logic     root_valid, root_ready;

   assign mat.m00 = req_bus.m00;
   assign mat.m01 = req_bus.m01;
   assign mat.m02 = req_bus.m02;
   assign mat.m10 = req_bus.m10;
   assign mat.m11 = req_bus.m11;
   assign mat.m12 = req_bus.m12;
   assign mat.m20 = req_bus.m20;
   assign mat.m21 = req_bus.m21;
   assign mat.m22 = req_bus.m22;

   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_mat    (mat),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_prep  (prep)
   );

   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_prep   (prep),
      .out_valid (root_valid),
      .out_ready (root_ready),
      .out_root  (root)
   );

   rmq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (root_valid),
      .in_ready  (root_ready),
      .in_root   (root),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_quat  (quat)
   );

   assign rsp_bus.qw    = quat.qw;
   assign rsp_bus.qx    = quat.qx;
   assign rsp_bus.qy    = quat.qy;
   assign rsp_bus.qz    = quat.qz;
   assign rsp_bus.pivot = quat.pivot;

endmodule
